>>> src/gaussian_polar_sampler_assert.svh
// Assertion macros shared by the polar Gaussian sampler.
`ifndef GAUSSIAN_POLAR_SAMPLER_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define GPS_ASSERT_NOW(label, clk_i, rst_n_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define GPS_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/gps_pkg.sv
// Shared constants and width functions of the polar Gaussian sampler.
package gps_pkg;

	localparam int LOG_FRAC = 28;
	localparam int MANT_W = LOG_FRAC + 1;
	localparam int LN2_W = 30;
	localparam logic [LN2_W-1:0] TWO_LN2_Q29 = 30'd744261118;

	localparam int CFG_W = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int MEAN_W = 32;
	localparam int SPREAD_W = 31;
	localparam logic [CFG_ADDR_W-1:0] CFG_MEAN = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPREAD = 2'd1;
	localparam logic [SPREAD_W-1:0] SPREAD_RESET = 31'd65536;

	localparam int DEF_UNIFORM_WIDTH = 16;
	localparam int DEF_SAMPLE_WIDTH = 32;

	// bits that hold the exponent of w, up to twice the fraction width
	function automatic int p_width(input int uw);
		return $clog2(2 * (uw - 1) + 1);
	endfunction

	function automatic int nl2_width(input int uw);
		return LOG_FRAC + p_width(uw);
	endfunction

	function automatic int lq_width(input int uw);
		return nl2_width(uw) + 1;
	endfunction

	function automatic int root_width(input int uw);
		return (lq_width(uw) + 5) >> 1;
	endfunction

	function automatic int div_width(input int uw);
		return (2 * (uw - 1) > 31) ? 31 : 2 * (uw - 1);
	endfunction

	function automatic int tot_width(input int uw, input int sw);
		int a;
		a = root_width(uw) + 17;
		a = (a > MEAN_W) ? a : MEAN_W;
		a = a + 1;
		return (a > sw) ? a : sw;
	endfunction

endpackage

>>> src/gps_front.sv
// Front pipeline: magnitudes, squares, rejection, exponent search, normalize.
module gps_front #(
	parameter int UNIFORM_WIDTH = gps_pkg::DEF_UNIFORM_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  logic [UNIFORM_WIDTH-1:0] ua,
	input  logic [UNIFORM_WIDTH-1:0] ub,
	output logic valid_s6,
	output logic [gps_pkg::MANT_W-1:0] mant_s6,
	output logic [gps_pkg::p_width(UNIFORM_WIDTH)-1:0] p_s6,
	output logic [gps_pkg::div_width(UNIFORM_WIDTH)-1:0] na_s6,
	output logic [gps_pkg::div_width(UNIFORM_WIDTH)-1:0] nb_s6,
	output logic [gps_pkg::div_width(UNIFORM_WIDTH)-1:0] d_s6,
	output logic sign_a_s6,
	output logic sign_b_s6
);
	import gps_pkg::*;

	localparam int F = UNIFORM_WIDTH - 1;
	localparam int W2 = 2 * F;
	localparam int MW = UNIFORM_WIDTH;
	localparam int PW = p_width(UNIFORM_WIDTH);
	localparam int DW = div_width(UNIFORM_WIDTH);
	localparam int GN = (W2 + 7) / 8;
	localparam int GPW = GN * 8;
	localparam int WIDE_W = W2 + LOG_FRAC;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [MW-1:0] mag_a_s1, mag_b_s1;
	logic sign_a_s1, sign_b_s1, sign_a_s2, sign_b_s2, sign_a_s3, sign_b_s3;
	logic sign_a_s4, sign_b_s4, sign_a_s5, sign_b_s5;
	logic [2*MW-1:0] sq_a_s2, sq_b_s2;
	logic [W2-1:0] w_s3, sq_a_s3, sq_b_s3, w_s4, sq_a_s4, sq_b_s4, w_s5, sq_a_s5, sq_b_s5;
	logic [GN-1:0] nz_s4;
	logic [2:0] li_s4 [GN];
	logic [PW-1:0] p_s5;

	logic [MW-1:0] ext_a, ext_b, mag_a_c, mag_b_c;
	logic [2*MW:0] wsum_c;
	logic ok_c;
	logic [GPW-1:0] wpad_c;
	logic [GN-1:0] nz_c;
	logic [2:0] li_c [GN];
	logic [PW-1:0] p_c;
	logic [WIDE_W-1:0] wide_c;
	logic [PW-1:0] k_c;

	assign ext_a = ua;
	assign ext_b = ub;
	assign mag_a_c = ua[UNIFORM_WIDTH-1] ? MW'(-ext_a) : ext_a;
	assign mag_b_c = ub[UNIFORM_WIDTH-1] ? MW'(-ext_b) : ext_b;

	assign wsum_c = (2*MW+1)'(sq_a_s2) + (2*MW+1)'(sq_b_s2);
	// drop the zero pair and anything on or outside the unit circle
	assign ok_c = (wsum_c != '0) && (wsum_c[2*MW:W2] == '0);

	assign wpad_c = GPW'(w_s3);

	always_comb begin
		for (int g = 0; g < GN; g++) begin
			nz_c[g] = |wpad_c[g*8 +: 8];
			li_c[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (wpad_c[g*8+b]) li_c[g] = 3'(b);
			end
		end
	end

	always_comb begin
		p_c = '0;
		for (int g = 0; g < GN; g++) begin
			if (nz_s4[g]) p_c = PW'(g * 8 + int'(li_s4[g]));
		end
	end

	assign wide_c = {w_s5, {LOG_FRAC{1'b0}}} >> p_s5;
	assign k_c = (int'(p_s5) > 30) ? PW'(int'(p_s5) - 30) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && ok_c;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_s1 <= mag_a_c;
			mag_b_s1 <= mag_b_c;
			sign_a_s1 <= ua[UNIFORM_WIDTH-1];
			sign_b_s1 <= ub[UNIFORM_WIDTH-1];

			sq_a_s2 <= (2*MW)'(mag_a_s1) * (2*MW)'(mag_a_s1);
			sq_b_s2 <= (2*MW)'(mag_b_s1) * (2*MW)'(mag_b_s1);
			sign_a_s2 <= sign_a_s1;
			sign_b_s2 <= sign_b_s1;

			w_s3 <= wsum_c[W2-1:0];
			sq_a_s3 <= sq_a_s2[W2-1:0];
			sq_b_s3 <= sq_b_s2[W2-1:0];
			sign_a_s3 <= sign_a_s2;
			sign_b_s3 <= sign_b_s2;

			nz_s4 <= nz_c;
			li_s4 <= li_c;
			w_s4 <= w_s3;
			sq_a_s4 <= sq_a_s3;
			sq_b_s4 <= sq_b_s3;
			sign_a_s4 <= sign_a_s3;
			sign_b_s4 <= sign_b_s3;

			p_s5 <= p_c;
			w_s5 <= w_s4;
			sq_a_s5 <= sq_a_s4;
			sq_b_s5 <= sq_b_s4;
			sign_a_s5 <= sign_a_s4;
			sign_b_s5 <= sign_b_s4;

			mant_s6 <= wide_c[MANT_W-1:0];
			p_s6 <= p_s5;
			d_s6 <= DW'(w_s5 >> k_c);
			na_s6 <= DW'(sq_a_s5 >> k_c);
			nb_s6 <= DW'(sq_b_s5 >> k_c);
			sign_a_s6 <= sign_a_s5;
			sign_b_s6 <= sign_b_s5;
		end
	end

endmodule

>>> src/gps_log.sv
// Pipelined base-2 logarithm by repeated squaring, ending in -log2(w) in Q.28.
module gps_log #(
	parameter int UNIFORM_WIDTH = gps_pkg::DEF_UNIFORM_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  logic [gps_pkg::MANT_W-1:0] mant,
	input  logic [gps_pkg::p_width(UNIFORM_WIDTH)-1:0] p,
	output logic valid_out,
	output logic [gps_pkg::nl2_width(UNIFORM_WIDTH)-1:0] nl2
);
	import gps_pkg::*;

	localparam int PW = p_width(UNIFORM_WIDTH);
	localparam int NLW = nl2_width(UNIFORM_WIDTH);
	localparam int TWO_F = 2 * (UNIFORM_WIDTH - 1);

	logic [MANT_W-1:0] mant_s [LOG_FRAC];
	logic [LOG_FRAC-1:0] frac_s [LOG_FRAC];
	logic [PW-1:0] p_s [LOG_FRAC];
	logic [LOG_FRAC:0] vld_s;

	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_step
		logic [MANT_W-1:0] m_in;
		logic [LOG_FRAC-1:0] f_in;
		logic [PW-1:0] p_in;
		logic v_in;
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0] m2;

		if (i == 0) begin : g_first
			assign m_in = mant;
			assign f_in = '0;
			assign p_in = p;
			assign v_in = valid;
		end else begin : g_next
			assign m_in = mant_s[i-1];
			assign f_in = frac_s[i-1];
			assign p_in = p_s[i-1];
			assign v_in = vld_s[i-1];
		end

		assign sq = (2*MANT_W)'(m_in) * (2*MANT_W)'(m_in);
		assign m2 = sq[2*MANT_W-1:LOG_FRAC];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (en) vld_s[i] <= v_in;
		end

		// a square of two or more sets this bit and is halved
		always_ff @(posedge clk) begin
			if (en) begin
				mant_s[i] <= m2[MANT_W] ? m2[MANT_W:1] : m2[MANT_W-1:0];
				frac_s[i] <= f_in | (LOG_FRAC'(m2[MANT_W]) << (LOG_FRAC - 1 - i));
				p_s[i] <= p_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[LOG_FRAC] <= 1'b0;
		else if (en) vld_s[LOG_FRAC] <= vld_s[LOG_FRAC-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl2 <= ((NLW'(TWO_F) - NLW'(p_s[LOG_FRAC-1])) << LOG_FRAC)
				- NLW'(frac_s[LOG_FRAC-1]);
		end
	end

	assign valid_out = vld_s[LOG_FRAC];

endmodule

>>> src/gps_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage.
module gps_div #(
	parameter int UNIFORM_WIDTH = gps_pkg::DEF_UNIFORM_WIDTH
) (
	input  logic clk,
	input  logic en,
	input  logic [1:0][gps_pkg::div_width(UNIFORM_WIDTH)-1:0] num,
	input  logic [gps_pkg::div_width(UNIFORM_WIDTH)-1:0] den,
	input  logic [1:0] sign,
	output logic [1:0][gps_pkg::MANT_W-1:0] quot,
	output logic [1:0] quot_sign
);
	import gps_pkg::*;

	localparam int DW = div_width(UNIFORM_WIDTH);
	localparam int QW = MANT_W;

	logic [1:0][DW:0] rem_s [QW];
	logic [1:0][QW-1:0] quo_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [1:0] sgn_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [1:0][DW:0] r_in;
		logic [1:0][QW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [1:0] s_in;
		logic [1:0][DW:0] r_nx;
		logic [1:0][QW-1:0] q_nx;

		if (i == 0) begin : g_first
			assign r_in[0] = {1'b0, num[0]};
			assign r_in[1] = {1'b0, num[1]};
			assign q_in = '0;
			assign d_in = den;
			assign s_in = sign;
		end else begin : g_next
			assign r_in = rem_s[i-1];
			assign q_in = quo_s[i-1];
			assign d_in = den_s[i-1];
			assign s_in = sgn_s[i-1];
		end

		always_comb begin
			logic ge;
			logic [DW:0] rd;
			for (int l = 0; l < 2; l++) begin
				ge = r_in[l] >= {1'b0, d_in};
				rd = ge ? (r_in[l] - {1'b0, d_in}) : r_in[l];
				r_nx[l] = {rd[DW-1:0], 1'b0};
				q_nx[l] = q_in[l] | (QW'(ge) << (QW - 1 - i));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= r_nx;
				quo_s[i] <= q_nx;
				den_s[i] <= d_in;
				sgn_s[i] <= s_in;
			end
		end
	end

	assign quot = quo_s[QW-1];
	assign quot_sign = sgn_s[QW-1];

endmodule

>>> src/gps_sqrt.sv
// Pipelined integer square root, two lanes, one root bit a stage.
module gps_sqrt #(
	parameter int UNIFORM_WIDTH = gps_pkg::DEF_UNIFORM_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid,
	input  logic [1:0][2*gps_pkg::root_width(UNIFORM_WIDTH)-1:0] rad,
	input  logic [1:0] sign,
	output logic valid_out,
	output logic [1:0][gps_pkg::root_width(UNIFORM_WIDTH)-1:0] root,
	output logic [1:0] root_sign
);
	import gps_pkg::*;

	localparam int XW = root_width(UNIFORM_WIDTH);
	localparam int RW = 2 * XW;

	logic [1:0][RW-1:0] rem_s [XW];
	logic [1:0][RW-1:0] res_s [XW];
	logic [1:0] sgn_s [XW];
	logic [XW-1:0] vld_s;

	for (genvar i = 0; i < XW; i++) begin : g_step
		localparam logic [RW-1:0] BITV = RW'(1) << (2 * (XW - 1 - i));
		logic [1:0][RW-1:0] n_in, r_in, n_nx, r_nx;
		logic [1:0] s_in;
		logic v_in;

		if (i == 0) begin : g_first
			assign n_in = rad;
			assign r_in = '0;
			assign s_in = sign;
			assign v_in = valid;
		end else begin : g_next
			assign n_in = rem_s[i-1];
			assign r_in = res_s[i-1];
			assign s_in = sgn_s[i-1];
			assign v_in = vld_s[i-1];
		end

		always_comb begin
			logic [RW:0] trial;
			for (int l = 0; l < 2; l++) begin
				trial = (RW+1)'(r_in[l]) + (RW+1)'(BITV);
				if ((RW+1)'(n_in[l]) >= trial) begin
					n_nx[l] = n_in[l] - trial[RW-1:0];
					r_nx[l] = (r_in[l] >> 1) + BITV;
				end else begin
					n_nx[l] = n_in[l];
					r_nx[l] = r_in[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (en) vld_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= n_nx;
				res_s[i] <= r_nx;
				sgn_s[i] <= s_in;
			end
		end
	end

	assign valid_out = vld_s[XW-1];
	assign root[0] = res_s[XW-1][0][XW-1:0];
	assign root[1] = res_s[XW-1][1][XW-1:0];
	assign root_sign = sgn_s[XW-1];

endmodule

>>> src/gaussian_polar_sampler.sv
// Top level of the Marsaglia polar Gaussian sampler: pair in, two scaled normal samples out.
// Stages: 6 front + 29 log/divide + 4 multiply + root width (19 at defaults) + 3 scale and
// output; the second sample of a pair follows the first.
// Throughput: a pair may enter every cycle while pair_stall is low; two samples per kept pair
// on an output of one sample per unstalled cycle set the sustained rate. Rejected pairs cost nothing.
// Reset (arst_n, async, low): clears all valid bits and the output buffer, mean 0, spread 1.0.
`include "gaussian_polar_sampler_assert.svh"
module gaussian_polar_sampler #(
	parameter int UNIFORM_WIDTH = gps_pkg::DEF_UNIFORM_WIDTH,
	parameter int SAMPLE_WIDTH = gps_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [gps_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [gps_pkg::CFG_W-1:0] cfg_wdata,
	input  logic pair_valid,
	output logic pair_stall,
	input  logic signed [UNIFORM_WIDTH-1:0] uniform_a,
	input  logic signed [UNIFORM_WIDTH-1:0] uniform_b,
	output logic sample_valid,
	input  logic sample_stall,
	output logic signed [SAMPLE_WIDTH-1:0] normal_sample,
	output logic last_of_pair
);
	import gps_pkg::*;

	localparam int PW = p_width(UNIFORM_WIDTH);
	localparam int DW = div_width(UNIFORM_WIDTH);
	localparam int NLW = nl2_width(UNIFORM_WIDTH);
	localparam int LQW = lq_width(UNIFORM_WIDTH);
	localparam int TW = LQW;
	localparam int XW = root_width(UNIFORM_WIDTH);
	localparam int TOTW = tot_width(UNIFORM_WIDTH, SAMPLE_WIDTH);
	// nl2 and lq are each cut in two so no product grows past about 32 bits a side
	localparam int NH = NLW / 2;
	localparam int PLW = NH + LN2_W;
	localparam int PHW = (NLW - NH) + LN2_W;
	localparam int PSUM_W = NLW + LN2_W;
	localparam int LH = LQW / 2;
	localparam int ALW = MANT_W + LH;
	localparam int AHW = MANT_W + (LQW - LH);
	localparam int ASUM_W = MANT_W + LQW;
	localparam int PRW = SPREAD_W + XW;
	localparam int SMW = XW + 16;

	// configuration registers
	logic signed [MEAN_W-1:0] mean_q;
	logic [SPREAD_W-1:0] spread_q;

	// global advance: the whole pipeline moves unless its last stage is blocked
	logic adv;

	// front outputs
	logic f_valid;
	logic [MANT_W-1:0] f_mant;
	logic [PW-1:0] f_p;
	logic [1:0][DW-1:0] f_num;
	logic [DW-1:0] f_den;
	logic [1:0] f_sign;

	// log and divider outputs
	logic l_valid;
	logic [NLW-1:0] l_nl2;
	logic [1:0][MANT_W-1:0] d_quot;
	logic [1:0] d_sign;

	// multiply stages
	logic v_s36, v_s37, v_s38, v_s39;
	logic [PLW-1:0] pl_s36;
	logic [PHW-1:0] ph_s36;
	logic [1:0][MANT_W-1:0] quo_s36, quo_s37;
	logic [1:0] sg_s36, sg_s37, sg_s38, sg_s39;
	logic [LQW-1:0] lq_s37;
	logic [1:0][ALW-1:0] pa_lo_s38;
	logic [1:0][AHW-1:0] pa_hi_s38;
	logic [1:0][TW-1:0] t_s39;

	// root and scale stages
	logic r_valid;
	logic [1:0][2*XW-1:0] r_rad;
	logic [1:0][XW-1:0] r_root;
	logic [1:0] r_sign;
	logic v_sp1, v_sp2;
	logic [1:0][PRW-1:0] prod_sp1;
	logic [1:0] sg_sp1;
	logic [1:0][SAMPLE_WIDTH-1:0] smp_sp2;

	// output buffer: both samples of a pair, sent first then second
	logic out_valid_q;
	logic phase_q;
	logic [1:0][SAMPLE_WIDTH-1:0] smp_q;

	logic [PSUM_W-1:0] psum_c;
	logic [1:0][ASUM_W-1:0] asum_c;
	logic [1:0][SAMPLE_WIDTH-1:0] smp_c;
	logic signed [TOTW-1:0] hi_c, lo_c;

	// accept a new pair whenever the end of the pipeline can move on
	assign adv = !v_sp2 || !out_valid_q || (phase_q && !sample_stall);
	assign pair_stall = !adv;

	// register writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			spread_q <= SPREAD_RESET;
		end else if (cfg_write) begin
			case (cfg_addr)
				CFG_MEAN: mean_q <= $signed(cfg_wdata[MEAN_W-1:0]);
				CFG_SPREAD: spread_q <= cfg_wdata[SPREAD_W-1:0];
				default: ;
			endcase
		end
	end

	// squares, rejection, exponent of w, normalized mantissa, divider operands
	gps_front #(.UNIFORM_WIDTH(UNIFORM_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.valid(pair_valid),
		.ua(uniform_a),
		.ub(uniform_b),
		.valid_s6(f_valid),
		.mant_s6(f_mant),
		.p_s6(f_p),
		.na_s6(f_num[0]),
		.nb_s6(f_num[1]),
		.d_s6(f_den),
		.sign_a_s6(f_sign[0]),
		.sign_b_s6(f_sign[1])
	);

	// -log2(w): 28 squaring stages plus one; carries the item valid
	gps_log #(.UNIFORM_WIDTH(UNIFORM_WIDTH)) u_log (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.valid(f_valid),
		.mant(f_mant),
		.p(f_p),
		.valid_out(l_valid),
		.nl2(l_nl2)
	);

	// u^2 / w for both lanes, 29 stages, lines up with the log
	gps_div #(.UNIFORM_WIDTH(UNIFORM_WIDTH)) u_div (
		.clk(clk),
		.en(adv),
		.num(f_num),
		.den(f_den),
		.sign(f_sign),
		.quot(d_quot),
		.quot_sign(d_sign)
	);

	// lq = nl2 * 2ln2, then t = ratio * lq, both truncated to Q.28
	assign psum_c = (PSUM_W'(ph_s36) << NH) + PSUM_W'(pl_s36);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			asum_c[l] = (ASUM_W'(pa_hi_s38[l]) << LH) + ASUM_W'(pa_lo_s38[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s36 <= 1'b0;
			v_s37 <= 1'b0;
			v_s38 <= 1'b0;
			v_s39 <= 1'b0;
		end else if (adv) begin
			v_s36 <= l_valid;
			v_s37 <= v_s36;
			v_s38 <= v_s37;
			v_s39 <= v_s38;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s36 <= PLW'(l_nl2[NH-1:0]) * PLW'(TWO_LN2_Q29);
			ph_s36 <= PHW'(l_nl2[NLW-1:NH]) * PHW'(TWO_LN2_Q29);
			quo_s36 <= d_quot;
			sg_s36 <= d_sign;

			lq_s37 <= psum_c[LN2_W-1 +: LQW];
			quo_s37 <= quo_s36;
			sg_s37 <= sg_s36;

			for (int l = 0; l < 2; l++) begin
				pa_lo_s38[l] <= ALW'(quo_s37[l]) * ALW'(lq_s37[LH-1:0]);
				pa_hi_s38[l] <= AHW'(quo_s37[l]) * AHW'(lq_s37[LQW-1:LH]);
				t_s39[l] <= asum_c[l][LOG_FRAC +: TW];
			end
			sg_s38 <= sg_s37;
			sg_s39 <= sg_s38;
		end
	end

	// |X| = floor(sqrt(16 t)), Q16.16
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			r_rad[l] = (2*XW)'({t_s39[l], 4'b0000});
		end
	end

	gps_sqrt #(.UNIFORM_WIDTH(UNIFORM_WIDTH)) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.valid(v_s39),
		.rad(r_rad),
		.sign(sg_s39),
		.valid_out(r_valid),
		.root(r_root),
		.root_sign(r_sign)
	);

	// saturation limits of the sample width, held in the wider sum
	assign hi_c = $signed({{(TOTW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
	assign lo_c = ~hi_c;

	// round the scaled magnitude half up, give it the sign of u, add the mean, clamp
	always_comb begin
		logic [PRW:0] rnd;
		logic [SMW-1:0] smag;
		logic signed [TOTW-1:0] sval, tot;
		for (int l = 0; l < 2; l++) begin
			rnd = (PRW+1)'(prod_sp1[l]) + (PRW+1)'(17'h08000);
			smag = rnd[16 +: SMW];
			sval = $signed(TOTW'(smag));
			if (sg_sp1[l]) sval = -sval;
			tot = $signed(TOTW'(mean_q)) + sval;
			if (tot > hi_c) smp_c[l] = hi_c[SAMPLE_WIDTH-1:0];
			else if (tot < lo_c) smp_c[l] = lo_c[SAMPLE_WIDTH-1:0];
			else smp_c[l] = tot[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp1 <= 1'b0;
			v_sp2 <= 1'b0;
		end else if (adv) begin
			v_sp1 <= r_valid;
			v_sp2 <= v_sp1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				prod_sp1[l] <= PRW'(spread_q) * PRW'(r_root[l]);
			end
			sg_sp1 <= r_sign;
			smp_sp2 <= smp_c;
		end
	end

	// load a finished pair, then hand out first and second sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (adv && v_sp2) begin
			out_valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (out_valid_q && !sample_stall) begin
			if (phase_q) out_valid_q <= 1'b0;
			phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_sp2) smp_q <= smp_sp2;
	end

	assign sample_valid = out_valid_q;
	assign last_of_pair = phase_q;
	assign normal_sample = phase_q ? smp_q[1] : smp_q[0];

	// a first sample taken is always followed by its partner
	`GPS_ASSERT_NEXT(a_pair_second, clk, arst_n, sample_valid && !last_of_pair && !sample_stall, sample_valid && last_of_pair, "first sample not followed by second")
	// a second sample taken never repeats
	`GPS_ASSERT_NEXT(a_pair_no_repeat, clk, arst_n, sample_valid && last_of_pair && !sample_stall, !(sample_valid && last_of_pair), "second sample repeated")
	// input stalls only behind a full output buffer
	`GPS_ASSERT_NOW(a_stall_cause, clk, arst_n, pair_stall, sample_valid && v_sp2, "input stalled with no blocked result")

endmodule
